// ===== hw/rtl/evr_pkg.sv =====
// Package: angle constants, CORDIC table, fixed-point helper types for the vertex rotator.
`default_nettype none
package evr_pkg;
    localparam int ANGLE_BITS   = 17;
    localparam int FULL_TURN    = 46080;
    localparam int HALF_TURN    = 23040;
    localparam int QUARTER_TURN = 11520;
    localparam int CORDIC_STEPS = 18;
    localparam int CORDIC_FRAC  = 30;
    localparam int ANGLE_SCALE  = 14;
    localparam int CW           = 34;
    localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;

    localparam logic [1:0] REG_ROLL  = 2'd0;
    localparam logic [1:0] REG_PITCH = 2'd1;
    localparam logic [1:0] REG_YAW   = 2'd2;

    typedef logic signed [CW-1:0] cw_t;

    function automatic cw_t atan_entry(input logic [4:0] i);
        case (i)
            5'd0:  atan_entry = 34'sd94371840;
            5'd1:  atan_entry = 34'sd55710950;
            5'd2:  atan_entry = 34'sd29436136;
            5'd3:  atan_entry = 34'sd14942242;
            5'd4:  atan_entry = 34'sd7500117;
            5'd5:  atan_entry = 34'sd3753715;
            5'd6:  atan_entry = 34'sd1877315;
            5'd7:  atan_entry = 34'sd938715;
            5'd8:  atan_entry = 34'sd469365;
            5'd9:  atan_entry = 34'sd234683;
            5'd10: atan_entry = 34'sd117342;
            5'd11: atan_entry = 34'sd58671;
            5'd12: atan_entry = 34'sd29335;
            5'd13: atan_entry = 34'sd14668;
            5'd14: atan_entry = 34'sd7334;
            5'd15: atan_entry = 34'sd3667;
            5'd16: atan_entry = 34'sd1833;
            5'd17: atan_entry = 34'sd917;
            default: atan_entry = '0;
        endcase
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/evr_matrix.sv =====
// Matrix builder: sequential CORDIC for three angles, then products into the 3x3 matrix.
`default_nettype none
module evr_matrix
    import evr_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 16
)(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic signed [ANGLE_BITS-1:0] roll,
    input  wire logic signed [ANGLE_BITS-1:0] pitch,
    input  wire logic signed [ANGLE_BITS-1:0] yaw,
    output logic busy,
    output logic signed [COEF_FRAC_BITS+1:0] mat [9]
);
    localparam int MW = COEF_FRAC_BITS + 2;
    localparam int PW = 2 * MW;
    localparam int RS = CORDIC_FRAC - COEF_FRAC_BITS;
    localparam logic signed [MW-1:0] ONE = MW'(1) <<< COEF_FRAC_BITS;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_REDUCE = 6'b000010,
        S_ITER   = 6'b000100,
        S_FINISH = 6'b001000,
        S_PROD1  = 6'b010000,
        S_PROD2  = 6'b100000
    } state_t;

    state_t state_reg;
    logic [1:0] ang_reg;
    logic [4:0] step_reg;
    logic neg_reg;
    logic zero_reg;
    cw_t x_reg, y_reg, z_reg;
    logic signed [MW-1:0] sn_reg [3];
    logic signed [MW-1:0] cs_reg [3];
    logic signed [MW-1:0] xsp_reg, ysp_reg;
    logic signed [MW-1:0] mat_reg [9];

    logic signed [ANGLE_BITS-1:0] ang_sel;
    logic signed [18:0] a0, a1, a2;
    logic neg_next;
    cw_t dx, dy, xr, yr;
    logic signed [MW-1:0] xc, yc;

    function automatic logic signed [MW-1:0] clampu(input cw_t v);
        if (v > cw_t'(ONE)) clampu = ONE;
        else if (v < -cw_t'(ONE)) clampu = -ONE;
        else clampu = v[MW-1:0];
    endfunction

    function automatic logic signed [MW:0] mulr(input logic signed [MW-1:0] p,
                                                input logic signed [MW-1:0] q);
        logic signed [PW-1:0] pr;
        pr = p * q + (PW'(1) <<< (COEF_FRAC_BITS - 1));
        mulr = (MW+1)'(pr >>> COEF_FRAC_BITS);
    endfunction

    function automatic logic signed [MW-1:0] clampw(input logic signed [MW+1:0] v);
        if (v > (MW+2)'(ONE)) clampw = ONE;
        else if (v < -(MW+2)'(ONE)) clampw = -ONE;
        else clampw = v[MW-1:0];
    endfunction

    always_comb
    begin
        unique case (ang_reg)
            REG_PITCH: ang_sel = pitch;
            REG_YAW:   ang_sel = yaw;
            default:   ang_sel = roll;
        endcase
        // 17-bit input stays within 1.5 turns of zero: one fold lands in [-180, 180)
        a0 = 19'(ang_sel);
        a1 = a0;
        if (a1 >= 19'sd23040) a1 = a1 - 19'sd46080;
        if (a1 < -19'sd23040) a1 = a1 + 19'sd46080;
        a2 = a1;
        neg_next = 1'b0;
        if (a1 > 19'sd11520)
        begin
            a2 = a1 - 19'sd23040;
            neg_next = 1'b1;
        end
        else if (a1 < -19'sd11520)
        begin
            a2 = a1 + 19'sd23040;
            neg_next = 1'b1;
        end
        dx = y_reg >>> step_reg;
        dy = x_reg >>> step_reg;
        xr = (x_reg + (cw_t'(1) <<< (RS - 1))) >>> RS;
        yr = (y_reg + (cw_t'(1) <<< (RS - 1))) >>> RS;
        xc = clampu(xr);
        yc = clampu(yr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_REDUCE;
            ang_reg <= REG_ROLL;
            step_reg <= '0;
        end
        else if (start)
        begin
            state_reg <= S_REDUCE;
            ang_reg <= REG_ROLL;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE: ;
                S_REDUCE:
                begin
                    step_reg <= '0;
                    state_reg <= S_ITER;
                end
                S_ITER:
                begin
                    if (step_reg == 5'(CORDIC_STEPS - 1)) state_reg <= S_FINISH;
                    step_reg <= step_reg + 5'd1;
                end
                S_FINISH:
                begin
                    if (ang_reg == REG_YAW) state_reg <= S_PROD1;
                    else
                    begin
                        ang_reg <= ang_reg + 2'd1;
                        state_reg <= S_REDUCE;
                    end
                end
                S_PROD1: state_reg <= S_PROD2;
                S_PROD2: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_REDUCE:
            begin
                neg_reg <= neg_next;
                zero_reg <= (a2 == '0);
                x_reg <= CORDIC_K;
                y_reg <= '0;
                z_reg <= cw_t'(a2) <<< ANGLE_SCALE;
            end
            S_ITER:
            begin
                if (!z_reg[CW-1])
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - atan_entry(step_reg);
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + atan_entry(step_reg);
                end
            end
            S_FINISH:
            begin
                if (zero_reg)
                begin
                    sn_reg[ang_reg] <= '0;
                    cs_reg[ang_reg] <= neg_reg ? -ONE : ONE;
                end
                else
                begin
                    sn_reg[ang_reg] <= neg_reg ? -yc : yc;
                    cs_reg[ang_reg] <= neg_reg ? -xc : xc;
                end
            end
            S_PROD1:
            begin
                xsp_reg <= MW'(mulr(cs_reg[2], sn_reg[1]));
                ysp_reg <= MW'(mulr(sn_reg[2], sn_reg[1]));
            end
            S_PROD2:
            begin
                mat_reg[0] <= clampw((MW+2)'(mulr(cs_reg[2], cs_reg[1])));
                mat_reg[1] <= clampw((MW+2)'(mulr(xsp_reg, sn_reg[0]))
                                   - (MW+2)'(mulr(sn_reg[2], cs_reg[0])));
                mat_reg[2] <= clampw((MW+2)'(mulr(xsp_reg, cs_reg[0]))
                                   + (MW+2)'(mulr(sn_reg[2], sn_reg[0])));
                mat_reg[3] <= clampw((MW+2)'(mulr(sn_reg[2], cs_reg[1])));
                mat_reg[4] <= clampw((MW+2)'(mulr(ysp_reg, sn_reg[0]))
                                   + (MW+2)'(mulr(cs_reg[2], cs_reg[0])));
                mat_reg[5] <= clampw((MW+2)'(mulr(ysp_reg, cs_reg[0]))
                                   - (MW+2)'(mulr(cs_reg[2], sn_reg[0])));
                mat_reg[6] <= clampw(-(MW+2)'(sn_reg[1]));
                mat_reg[7] <= clampw((MW+2)'(mulr(cs_reg[1], sn_reg[0])));
                mat_reg[8] <= clampw((MW+2)'(mulr(cs_reg[1], cs_reg[0])));
            end
            default: ;
        endcase
    end

    assign busy = (state_reg != S_IDLE) || start;
    assign mat = mat_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/evr_datapath.sv =====
// Vertex pipeline: multiply, sum, round/saturate, output register with stall.
`default_nettype none
module evr_datapath
    import evr_pkg::*;
#(
    parameter int COORD_WIDTH    = 24,
    parameter int COEF_FRAC_BITS = 16
)(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_stall,
    input  wire logic signed [COORD_WIDTH-1:0] vx,
    input  wire logic signed [COORD_WIDTH-1:0] vy,
    input  wire logic signed [COORD_WIDTH-1:0] vz,
    input  wire logic signed [COEF_FRAC_BITS+1:0] mat [9],
    output logic out_valid,
    input  wire logic out_stall,
    output logic signed [COORD_WIDTH-1:0] rx,
    output logic signed [COORD_WIDTH-1:0] ry,
    output logic signed [COORD_WIDTH-1:0] rz
);
    localparam int MW = COEF_FRAC_BITS + 2;
    localparam int PW = COORD_WIDTH + MW;
    localparam int SW = PW + 2;
    localparam logic signed [SW-1:0] HI = SW'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
    localparam logic signed [SW-1:0] LO = -HI - SW'(1);

    logic v1_reg, v2_reg, v3_reg;
    logic signed [PW-1:0] p_reg [9];
    logic signed [SW-1:0] s_reg [3];
    logic signed [COORD_WIDTH-1:0] o_reg [3];
    logic adv;
    logic signed [COORD_WIDTH-1:0] vin [3];
    logic signed [SW-1:0] rsum [3];

    assign adv = !(v3_reg && out_stall);
    assign in_stall = !adv;
    assign vin[0] = vx;
    assign vin[1] = vy;
    assign vin[2] = vz;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
            rsum[r] = (s_reg[r] + (SW'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                    p_reg[r*3+k] <= PW'(vin[k]) * PW'(mat[r*3+k]);
                s_reg[r] <= SW'(p_reg[r*3]) + SW'(p_reg[r*3+1]) + SW'(p_reg[r*3+2]);
                if (rsum[r] > HI) o_reg[r] <= HI[COORD_WIDTH-1:0];
                else if (rsum[r] < LO) o_reg[r] <= LO[COORD_WIDTH-1:0];
                else o_reg[r] <= rsum[r][COORD_WIDTH-1:0];
            end
        end
    end

    assign out_valid = v3_reg;
    assign rx = o_reg[0];
    assign ry = o_reg[1];
    assign rz = o_reg[2];
endmodule
`default_nettype wire

// ===== hw/rtl/euler_vertex_rotation.sv =====
// Top level: ZYX Euler rotation of a vertex stream.
// channel | direction | handshake             | payload
// vertex  | in        | vertex_valid/stall    | vertex_x, vertex_y, vertex_z
// rotated | out       | rotated_valid/stall   | rotated_x, rotated_y, rotated_z
// cfg     | in        | cfg_valid/cfg_ready   | cfg_index, cfg_data
// One vertex per cycle when not stalled, through the multiply/sum/saturate stages.
// Each angle write (and reset) runs the matrix builder: range reduction, CORDIC
// iterations and finish per angle, then the products; vertices are held off meanwhile.
// An angle write during a build restarts the build from the roll angle.
// A stall on a valid output freezes the whole pipeline; nothing is lost or repeated.
`default_nettype none
module euler_vertex_rotation
    import evr_pkg::*;
#(
    parameter int COORD_WIDTH    = 24,
    parameter int COEF_FRAC_BITS = 16
)(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_valid,
    output logic cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [ANGLE_BITS-1:0] cfg_data,
    input  wire logic vertex_valid,
    output logic vertex_stall,
    input  wire logic signed [COORD_WIDTH-1:0] vertex_x,
    input  wire logic signed [COORD_WIDTH-1:0] vertex_y,
    input  wire logic signed [COORD_WIDTH-1:0] vertex_z,
    output logic rotated_valid,
    input  wire logic rotated_stall,
    output logic signed [COORD_WIDTH-1:0] rotated_x,
    output logic signed [COORD_WIDTH-1:0] rotated_y,
    output logic signed [COORD_WIDTH-1:0] rotated_z
);
    logic signed [ANGLE_BITS-1:0] roll_reg, pitch_reg, yaw_reg;
    logic start, busy, dp_stall, dp_valid;
    logic signed [COEF_FRAC_BITS+1:0] mat [9];

    assign cfg_ready = 1'b1;
    assign start = cfg_valid && (cfg_index == REG_ROLL || cfg_index == REG_PITCH
                                 || cfg_index == REG_YAW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_reg <= '0;
            pitch_reg <= '0;
            yaw_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ROLL:  roll_reg <= cfg_data;
                REG_PITCH: pitch_reg <= cfg_data;
                REG_YAW:   yaw_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    evr_matrix #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_matrix (
        .clk(clk), .rst_n(rst_n), .start(start),
        .roll(roll_reg), .pitch(pitch_reg), .yaw(yaw_reg),
        .busy(busy), .mat(mat)
    );

    assign dp_valid = vertex_valid && !busy;
    assign vertex_stall = dp_stall || busy;

    evr_datapath #(.COORD_WIDTH(COORD_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .in_valid(dp_valid), .in_stall(dp_stall),
        .vx(vertex_x), .vy(vertex_y), .vz(vertex_z), .mat(mat),
        .out_valid(rotated_valid), .out_stall(rotated_stall),
        .rx(rotated_x), .ry(rotated_y), .rz(rotated_z)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/evr_checker.sv =====
// Port-level checks for the vertex rotator, bound to the top level.
`default_nettype none
module evr_checker
    import evr_pkg::*;
#(
    parameter int COORD_WIDTH = 24
)(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic vertex_valid,
    input wire logic vertex_stall,
    input wire logic rotated_valid,
    input wire logic rotated_stall,
    input wire logic [COORD_WIDTH-1:0] rotated_x
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rotated_valid && rotated_stall |=> rotated_valid && $stable(rotated_x))
        else $error("rotated request dropped or changed under stall");
    a_backp: assert property (@(posedge clk) disable iff (!rst_n)
        rotated_valid && rotated_stall |-> vertex_stall)
        else $error("input taken while output stalled");
    a_reset: assert property (@(posedge clk) $rose(rst_n) |-> !rotated_valid)
        else $error("output valid out of reset");
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        !rotated_stall && !$past(rotated_stall) && !$past(rotated_stall, 2)
        && $past(vertex_valid, 3) && !$past(vertex_stall, 3) |-> rotated_valid)
        else $error("accepted vertex did not arrive");
endmodule

bind euler_vertex_rotation evr_checker #(.COORD_WIDTH(COORD_WIDTH)) u_evr_checker (
    .clk(clk), .rst_n(rst_n), .vertex_valid(vertex_valid), .vertex_stall(vertex_stall),
    .rotated_valid(rotated_valid), .rotated_stall(rotated_stall), .rotated_x(rotated_x)
);
`default_nettype wire
